### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh - concurrent assertion helpers
// Clocked assertion macros used by the RTL; they compile away for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  `ASSERT_PROP(label, clk, rst, !(cond), msg)

`else

`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

### src/hstf_pkg.sv
// ----------------------------------------------------------------------------
// hstf_pkg - handle slot table shared definitions
// Field widths, command and status codes, and the result beat layout.
// ----------------------------------------------------------------------------
package hstf_pkg;

  localparam int HANDLE_W = 9;
  localparam int VALUE_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int DATA_W   = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [VALUE_W-1:0]  value;
    status_t             status;
  } result_t;

endpackage

### src/hstf_ram.sv
// ----------------------------------------------------------------------------
// hstf_ram - simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module hstf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when it hits the address being written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/handle_slot_table_free_fifo.sv
// ----------------------------------------------------------------------------
// handle_slot_table_free_fifo - handle table with a queue of freed slots
// Stores values under one-based handles, recycling freed slots oldest first.
// ----------------------------------------------------------------------------
// Usage
//   Requests arrive as beats on the s_ channel: s_tuser carries the command
//   (add, remove, get), s_tdata the handle and the value. Every request
//   produces exactly one result beat on the m_ channel: m_tdata carries the
//   handle assigned by an add and the value read by a get, m_tuser the status.
// Pipeline and throughput
//   A request passes through the request stage, where its slot and free queue
//   RAM reads land, and then the result register, which raises m_tvalid. One
//   request is accepted per cycle while the result side is not stalled; the
//   slot RAM read is issued as the beat is taken, followed by the decision
//   logic and the RAM/queue write.
// Reset
//   rst clears the used mark, the free queue pointers and count, and all
//   valid flags. The slot and queue RAMs are not cleared: only entries that
//   have been written are ever read, so no clearing pass is needed.
// Stall
//   When m_tready is low the result register holds; the request stage can
//   still take one more beat, after which s_tready drops until the result
//   is taken.
module handle_slot_table_free_fifo #(
  parameter int SLOTS      = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // s_tdata, from bit 0: handle[8:0], value[40:9], zero padding[47:41]
  input  logic [hstf_pkg::DATA_W-1:0]  s_tdata,
  // s_tuser, from bit 0: command[1:0]
  input  logic [hstf_pkg::CMD_W-1:0]   s_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // m_tdata, from bit 0: result_handle[8:0], read_value[40:9], zero padding[47:41]
  output logic [hstf_pkg::DATA_W-1:0]  m_tdata,
  // m_tuser, from bit 0: status[1:0]
  output logic [hstf_pkg::STATUS_W-1:0] m_tuser
);

  `include "assert_macros.svh"

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int STORE_W = (VALUE_BITS < hstf_pkg::VALUE_W) ? VALUE_BITS : hstf_pkg::VALUE_W;
  localparam int CMP_W   = (CNT_W > hstf_pkg::HANDLE_W) ? CNT_W : hstf_pkg::HANDLE_W;
  localparam int PAD_W   = hstf_pkg::DATA_W - hstf_pkg::HANDLE_W - hstf_pkg::VALUE_W;

  // Incoming beat fields.
  logic [hstf_pkg::HANDLE_W-1:0] in_handle;
  logic [hstf_pkg::VALUE_W-1:0]  in_value;
  logic [CMP_W-1:0]              in_handle_m1;
  logic                          accept;

  // Request stage: the beat whose RAM reads are now in the read registers.
  logic                          p_valid;
  hstf_pkg::cmd_t                p_cmd;
  logic [hstf_pkg::HANDLE_W-1:0] p_handle;
  logic [STORE_W-1:0]            p_value;
  logic                          p_fire;
  logic                          out_free;

  // Table state.
  logic [CNT_W-1:0] used_count, used_count_next;
  logic [IDX_W-1:0] free_head, free_head_next;
  logic [IDX_W-1:0] free_tail, free_tail_next;
  logic [CNT_W-1:0] free_count, free_count_next;

  // RAM ports.
  logic [STORE_W-1:0] slot_rdata;
  logic [IDX_W-1:0]   slot_raddr;
  logic               slot_we;
  logic [IDX_W-1:0]   slot_waddr;
  logic [STORE_W-1:0] slot_wdata;
  logic [IDX_W-1:0]   fq_rdata;
  logic               fq_we;

  // Bypass of a write that landed on the address read in the same cycle.
  logic               slot_fwd_hit;
  logic [STORE_W-1:0] slot_fwd_data;
  logic               fq_fwd_hit;
  logic [IDX_W-1:0]   fq_fwd_data;

  // Decision logic.
  logic [STORE_W-1:0] cur_slot;
  logic [IDX_W-1:0]   cur_fq;
  logic [IDX_W-1:0]   pop_idx;
  logic [CMP_W-1:0]   p_handle_x;
  logic [CMP_W-1:0]   p_handle_m1;
  logic [CMP_W-1:0]   used_x;
  logic [CMP_W-1:0]   pop_handle;
  logic [CMP_W-1:0]   append_handle;
  logic               live;
  logic               want_we;
  logic               want_pop;
  logic               want_push;
  logic               want_append;
  logic               pop;
  logic               push;
  hstf_pkg::result_t  res;

  assign in_handle    = s_tdata[hstf_pkg::HANDLE_W-1:0];
  assign in_value     = s_tdata[hstf_pkg::HANDLE_W +: hstf_pkg::VALUE_W];
  assign in_handle_m1 = CMP_W'(in_handle) - CMP_W'(1);
  assign slot_raddr   = in_handle_m1[IDX_W-1:0];

  assign out_free = !m_tvalid || m_tready;
  assign p_fire   = p_valid && out_free;
  assign s_tready = !p_valid || out_free;
  assign accept   = s_tvalid && s_tready;

  assign cur_slot = slot_fwd_hit ? slot_fwd_data : slot_rdata;
  assign cur_fq   = fq_fwd_hit ? fq_fwd_data : fq_rdata;
  // A queued index beyond the table maps to slot zero.
  assign pop_idx  = (CNT_W'(cur_fq) >= CNT_W'(SLOTS)) ? '0 : cur_fq;

  assign p_handle_x    = CMP_W'(p_handle);
  assign p_handle_m1   = p_handle_x - CMP_W'(1);
  assign used_x        = CMP_W'(used_count);
  assign pop_handle    = CMP_W'(pop_idx) + CMP_W'(1);
  assign append_handle = used_x + CMP_W'(1);
  // A handle is live when it is in range and its entry is not zero.
  assign live = (p_handle_x != '0) && (p_handle_x <= used_x) && (cur_slot != '0);

  always_comb begin
    res         = '0;
    res.status  = hstf_pkg::ST_OK;
    want_we     = 1'b0;
    want_pop    = 1'b0;
    want_push   = 1'b0;
    want_append = 1'b0;
    slot_waddr  = p_handle_m1[IDX_W-1:0];
    slot_wdata  = '0;
    case (p_cmd)
      hstf_pkg::CMD_ADD: begin
        if (free_count != '0) begin
          want_pop   = 1'b1;
          want_we    = 1'b1;
          slot_waddr = pop_idx;
          slot_wdata = p_value;
          res.handle = pop_handle[hstf_pkg::HANDLE_W-1:0];
        end else if (used_count < CNT_W'(SLOTS)) begin
          want_append = 1'b1;
          want_we     = 1'b1;
          slot_waddr  = used_count[IDX_W-1:0];
          slot_wdata  = p_value;
          res.handle  = append_handle[hstf_pkg::HANDLE_W-1:0];
        end else begin
          res.status = hstf_pkg::ST_FULL;
        end
      end
      hstf_pkg::CMD_REMOVE: begin
        if (live) begin
          want_we   = 1'b1;
          want_push = (free_count < CNT_W'(SLOTS));
        end else begin
          res.status = hstf_pkg::ST_NOT_FOUND;
        end
      end
      hstf_pkg::CMD_GET: begin
        if (live) begin
          res.value = hstf_pkg::VALUE_W'(cur_slot);
        end else begin
          res.status = hstf_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  assign slot_we = want_we && p_fire;
  assign pop     = want_pop && p_fire;
  assign push    = want_push && p_fire;
  assign fq_we   = push;

  always_comb begin
    used_count_next = used_count;
    if (want_append && p_fire) begin
      used_count_next = used_count + CNT_W'(1);
    end
    free_head_next = free_head;
    if (pop) begin
      free_head_next = (free_head == IDX_W'(SLOTS - 1)) ? '0 : free_head + IDX_W'(1);
    end
    free_tail_next = free_tail;
    if (push) begin
      free_tail_next = (free_tail == IDX_W'(SLOTS - 1)) ? '0 : free_tail + IDX_W'(1);
    end
    free_count_next = free_count;
    if (push && !pop) begin
      free_count_next = free_count + CNT_W'(1);
    end else if (pop && !push) begin
      free_count_next = free_count - CNT_W'(1);
    end
  end

  // Slot values; the read for a request is issued as its beat is accepted.
  hstf_ram #(
    .WIDTH (STORE_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .re    (accept),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Free queue; it is read at the head as it stands after the current pop.
  hstf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (SLOTS)
  ) u_free_ram (
    .clk   (clk),
    .we    (fq_we),
    .waddr (free_tail),
    .wdata (slot_waddr),
    .re    (accept),
    .raddr (free_head_next),
    .rdata (fq_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid      <= 1'b0;
      m_tvalid     <= 1'b0;
      used_count   <= '0;
      free_head    <= '0;
      free_tail    <= '0;
      free_count   <= '0;
      slot_fwd_hit <= 1'b0;
      fq_fwd_hit   <= 1'b0;
    end else begin
      used_count <= used_count_next;
      free_head  <= free_head_next;
      free_tail  <= free_tail_next;
      free_count <= free_count_next;
      if (accept) begin
        p_valid      <= 1'b1;
        slot_fwd_hit <= slot_we && (slot_waddr == slot_raddr);
        fq_fwd_hit   <= push && (free_tail == free_head_next);
      end else if (p_fire) begin
        p_valid <= 1'b0;
      end
      if (p_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      p_cmd         <= hstf_pkg::cmd_t'(s_tuser);
      p_handle      <= in_handle;
      p_value       <= in_value[STORE_W-1:0];
      slot_fwd_data <= slot_wdata;
      fq_fwd_data   <= slot_waddr;
    end
    if (p_fire) begin
      m_tdata <= {PAD_W'(0), res.value, res.handle};
      m_tuser <= res.status;
    end
  end

  // Every queued slot was appended once, so the queue never outgrows the used mark.
  `ASSERT_PROP(a_free_within_used, clk, rst, free_count <= used_count,
               "free queue holds more slots than were ever appended")
  `ASSERT_PROP(a_used_bounded, clk, rst, used_count <= CNT_W'(SLOTS),
               "used mark beyond table capacity")
  `ASSERT_PROP(a_empty_queue_ptrs, clk, rst, (free_count == '0) |-> (free_head == free_tail),
               "empty free queue with head and tail apart")
  // A queue bypass only arises when the pushed slot became the sole entry.
  `ASSERT_PROP(a_fq_bypass_single, clk, rst,
               (fq_fwd_hit && p_valid) |-> (free_count == CNT_W'(1)),
               "free queue bypass taken while queue does not hold exactly one slot")
  `ASSERT_PROP(a_handle_only_ok, clk, rst,
               (m_tvalid && (m_tuser != hstf_pkg::ST_OK)) |->
                 (m_tdata[hstf_pkg::HANDLE_W-1:0] == '0),
               "failed request returned a nonzero handle")

endmodule
